// ----- hw/rtl/spalu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spalu_pkg
// Shared types and constants for the saturating pixel arithmetic unit.
// ----------------------------------------------------------------------------
package spalu_pkg;

    localparam int unsigned PIX_W   = 16;
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned REG_W   = 32;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned M_DATA_W = 16;

    localparam logic [PIX_W-1:0] MAX8    = 16'h00ff;
    localparam logic [PIX_W-1:0] MAX16   = 16'hffff;
    localparam logic [7:0]       MSB_BIT = 8'h80;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD       = 3'd0,
        CMD_SUB       = 3'd1,
        CMD_ABSDIFF   = 3'd2,
        CMD_SCALE     = 3'd3,
        CMD_THRESHOLD = 3'd4
    } cmd_t;

    // {first_wide, second_wide, result_wide}
    typedef enum logic [2:0] {
        FMT_NNN = 3'b000,
        FMT_NNW = 3'b001,
        FMT_WNN = 3'b100,
        FMT_WWW = 3'b111
    } fmt_t;

    typedef enum logic [2:0] {
        REG_FIRST_WIDE  = 3'd0,
        REG_SECOND_WIDE = 3'd1,
        REG_RESULT_WIDE = 3'd2,
        REG_SCALE       = 3'd3,
        REG_THRESHOLD   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic             first_wide;
        logic             second_wide;
        logic             result_wide;
        logic [REG_W-1:0] scale_factor;
        logic [REG_W-1:0] threshold_level;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [PIX_W-1:0] pixel_a;
        logic [PIX_W-1:0] pixel_b;
        logic             final_pixel;
    } item_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             status;
        logic             end_of_run;
    } result_t;

    typedef struct packed {
        logic [7:0] bits;
        logic [2:0] count;
    } pack_t;

endpackage

// ----- hw/rtl/spalu_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spalu_regs
// APB register file holding the format bits, scale factor and threshold.
// ----------------------------------------------------------------------------
module spalu_regs import spalu_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]  pwdata,
    output logic [REG_W-1:0]  prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_FIRST_WIDE:  cfg_next.first_wide      = pwdata[0];
                REG_SECOND_WIDE: cfg_next.second_wide     = pwdata[0];
                REG_RESULT_WIDE: cfg_next.result_wide     = pwdata[0];
                REG_SCALE:       cfg_next.scale_factor    = pwdata;
                REG_THRESHOLD:   cfg_next.threshold_level = pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_FIRST_WIDE:  prdata = {{(REG_W-1){1'b0}}, cfg_reg.first_wide};
            REG_SECOND_WIDE: prdata = {{(REG_W-1){1'b0}}, cfg_reg.second_wide};
            REG_RESULT_WIDE: prdata = {{(REG_W-1){1'b0}}, cfg_reg.result_wide};
            REG_SCALE:       prdata = cfg_reg.scale_factor;
            REG_THRESHOLD:   prdata = cfg_reg.threshold_level;
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_wide      <= 1'b0;
            cfg_reg.second_wide     <= 1'b0;
            cfg_reg.result_wide     <= 1'b0;
            cfg_reg.scale_factor    <= 32'd1;
            cfg_reg.threshold_level <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hw/rtl/spalu_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spalu_datapath
// Single-pass pixel arithmetic: saturating add, floored subtract, absolute
// difference, scale and threshold bit packing.
// ----------------------------------------------------------------------------
module spalu_datapath import spalu_pkg::*; (
    input  cfg_t    cfg,
    input  item_t   item,
    input  pack_t   pack,
    output result_t res,
    output logic    has_result,
    output pack_t   pack_next
);

    logic [PIX_W-1:0]   a;
    logic [PIX_W-1:0]   b;
    logic [2:0]         fmt;
    logic [PIX_W:0]     sum;
    logic [PIX_W-1:0]   diff_ab;
    logic [PIX_W-1:0]   diff_ba;
    logic               a_lt_b;
    logic [PIX_W-1:0]   res_lim;
    logic [PIX_W-1:0]   mul;
    logic [2*PIX_W-1:0] prod;
    logic [PIX_W-1:0]   scaled;
    logic [PIX_W-1:0]   a_lim;
    logic [PIX_W-1:0]   thr;
    logic               hit;
    logic [7:0]         bits_or;
    logic               ok;

    always_comb begin
        a       = cfg.first_wide  ? item.pixel_a : {8'h00, item.pixel_a[7:0]};
        b       = cfg.second_wide ? item.pixel_b : {8'h00, item.pixel_b[7:0]};
        fmt     = {cfg.first_wide, cfg.second_wide, cfg.result_wide};
        sum     = {1'b0, a} + {1'b0, b};
        diff_ab = a - b;
        diff_ba = b - a;
        a_lt_b  = a < b;

        res_lim = cfg.result_wide ? MAX16 : MAX8;
        mul     = (cfg.scale_factor > {16'h0000, res_lim}) ? res_lim
                                                           : cfg.scale_factor[15:0];
        prod    = a * mul;
        scaled  = (prod > {16'h0000, res_lim}) ? res_lim : prod[15:0];

        a_lim   = cfg.first_wide ? MAX16 : MAX8;
        thr     = (cfg.threshold_level > {16'h0000, a_lim}) ? a_lim
                                                            : cfg.threshold_level[15:0];
        hit     = a >= thr;
        bits_or = pack.bits | (hit ? (MSB_BIT >> pack.count) : 8'h00);

        ok             = 1'b0;
        has_result     = 1'b1;
        pack_next      = pack;
        res.value      = '0;
        res.end_of_run = item.final_pixel;

        case (item.command)
            CMD_ADD: begin
                if (fmt == FMT_NNN) begin
                    ok        = 1'b1;
                    res.value = (sum > {1'b0, MAX8}) ? MAX8 : sum[15:0];
                end else if (fmt == FMT_NNW) begin
                    ok        = 1'b1;
                    res.value = sum[15:0];
                end else if (fmt == FMT_WWW) begin
                    ok        = 1'b1;
                    res.value = sum[16] ? MAX16 : sum[15:0];
                end
            end
            CMD_SUB: begin
                if (fmt == FMT_NNN || fmt == FMT_WWW) begin
                    ok        = 1'b1;
                    res.value = a_lt_b ? '0 : diff_ab;
                end else if (fmt == FMT_WNN) begin
                    ok        = 1'b1;
                    res.value = a_lt_b ? '0 : {8'h00, diff_ab[7:0]};
                end
            end
            CMD_ABSDIFF: begin
                if (fmt == FMT_NNN) begin
                    ok        = 1'b1;
                    res.value = a_lt_b ? diff_ba : diff_ab;
                end
            end
            CMD_SCALE: begin
                if (!cfg.first_wide || cfg.result_wide) begin
                    ok        = 1'b1;
                    res.value = scaled;
                end
            end
            CMD_THRESHOLD: begin
                ok = 1'b1;
                if (pack.count == 3'd7 || item.final_pixel) begin
                    res.value = {8'h00, bits_or};
                    pack_next = '0;
                end else begin
                    has_result      = 1'b0;
                    pack_next.bits  = bits_or;
                    pack_next.count = pack.count + 3'd1;
                end
            end
            default: ;
        endcase

        res.status = ~ok;
    end

endmodule

// ----- hw/rtl/saturating_pixel_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturating_pixel_arithmetic_unit
// Streaming pixel ALU with saturating arithmetic and binary threshold packing.
// ----------------------------------------------------------------------------
// Takes one word per clock and presents its result from the output
// register: the word is captured in an input register, worked on by a
// single pass of logic (one 16x16 multiply or one add and compare) and
// written to the output register. Threshold words produce a result only
// every eighth pixel or on tlast. Throughput is one word per cycle as long
// as the result side takes words.
module saturating_pixel_arithmetic_unit import spalu_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // APB configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [REG_W-1:0]    pwdata,
    output logic [REG_W-1:0]    prdata,
    output logic                pready,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // command[2:0], pixel_a[18:3], pixel_b[34:19], zero pad
    input  logic                s_tlast,   // final_pixel
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // value[15:0]
    output logic                m_tuser,   // status
    output logic                m_tlast    // end_of_run
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    pack_t   pack_reg;
    pack_t   pack_next;
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t dp_res;
    logic    dp_has_result;
    logic    out_free;
    logic    advance;
    logic    s_accept;

    spalu_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spalu_datapath u_datapath (
        .cfg        (cfg),
        .item       (item_reg),
        .pack       (pack_reg),
        .res        (dp_res),
        .has_result (dp_has_result),
        .pack_next  (pack_next)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (out_free || !dp_has_result);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && dp_has_result) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pack_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                pack_reg <= pack_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.command     <= s_tdata[2:0];
            item_reg.pixel_a     <= s_tdata[18:3];
            item_reg.pixel_b     <= s_tdata[34:19];
            item_reg.final_pixel <= s_tlast;
        end
        if (advance && dp_has_result) begin
            out_reg <= dp_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.value;
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.end_of_run;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the saturating pixel arithmetic unit. A scoreboard
// predicts every result word from the accepted pixel words and the current
// register settings: the add, subtract, absolute difference and scale paths,
// the unsupported-format errors and the MSB-first threshold packing. Both
// stream sides idle at random, and one long result stall backs up the input.
// Registers are rewritten between phases through the APB port and read back.
// ----------------------------------------------------------------------------
module tb;
    import spalu_pkg::*;

    localparam logic ST_OK      = 1'b0;
    localparam logic ST_BAD_FMT = 1'b1;
    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 110;

    class pixel_scoreboard;
        logic        first_wide, second_wide, result_wide;
        logic [31:0] scale_factor, threshold_level;
        logic [7:0]  pack_bits;
        logic [2:0]  pack_count;
        result_t     predicted_pixels[$];
        int          errors, pixels_noted, results_checked;

        function new();
            first_wide      = 1'b0;
            second_wide     = 1'b0;
            result_wide     = 1'b0;
            scale_factor    = 32'd1;
            threshold_level = 32'd0;
            pack_bits       = '0;
            pack_count      = '0;
            errors          = 0;
            pixels_noted    = 0;
            results_checked = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] v);
            case (idx)
                REG_FIRST_WIDE:  first_wide      = v[0];
                REG_SECOND_WIDE: second_wide     = v[0];
                REG_RESULT_WIDE: result_wide     = v[0];
                REG_SCALE:       scale_factor    = v;
                REG_THRESHOLD:   threshold_level = v;
                default: ;
            endcase
        endfunction

        function void note_pixel(item_t it);
            logic [31:0] a, b, lim, sum, diff, mul, prod, thr_lim, thr;
            logic [2:0]  fmt;
            result_t     r;
            bit          ok;
            a       = first_wide  ? 32'(it.pixel_a) : 32'(it.pixel_a[7:0]);
            b       = second_wide ? 32'(it.pixel_b) : 32'(it.pixel_b[7:0]);
            fmt     = {first_wide, second_wide, result_wide};
            lim     = result_wide ? 32'(MAX16) : 32'(MAX8);
            sum     = a + b;
            diff    = a - b;
            ok      = 1'b0;
            r       = '0;
            r.end_of_run = it.final_pixel;
            pixels_noted++;
            case (it.command)
                CMD_ADD: begin
                    if (fmt == FMT_NNN || fmt == FMT_WWW) begin
                        r.value = (sum > lim) ? lim[15:0] : sum[15:0];
                        ok = 1'b1;
                    end else if (fmt == FMT_NNW) begin
                        r.value = sum[15:0];
                        ok = 1'b1;
                    end
                end
                CMD_SUB: begin
                    if (fmt == FMT_NNN || fmt == FMT_WWW) begin
                        r.value = (a < b) ? 16'd0 : diff[15:0];
                        ok = 1'b1;
                    end else if (fmt == FMT_WNN) begin
                        r.value = (a < b) ? 16'd0 : {8'h00, diff[7:0]};
                        ok = 1'b1;
                    end
                end
                CMD_ABSDIFF: begin
                    if (fmt == FMT_NNN) begin
                        r.value = (a < b) ? 16'(b - a) : diff[15:0];
                        ok = 1'b1;
                    end
                end
                CMD_SCALE: begin
                    if (!first_wide || result_wide) begin
                        mul     = (scale_factor > lim) ? lim : scale_factor;
                        prod    = a * mul;
                        r.value = (prod > lim) ? lim[15:0] : prod[15:0];
                        ok = 1'b1;
                    end
                end
                CMD_THRESHOLD: begin
                    thr_lim = first_wide ? 32'(MAX16) : 32'(MAX8);
                    thr = (threshold_level > thr_lim) ? thr_lim : threshold_level;
                    if (a >= thr)
                        pack_bits = pack_bits | (MSB_BIT >> pack_count);
                    if (pack_count == 3'd7 || it.final_pixel) begin
                        r.value    = {8'h00, pack_bits};
                        r.status   = ST_OK;
                        pack_bits  = '0;
                        pack_count = '0;
                        predicted_pixels.push_back(r);
                    end else begin
                        pack_count = pack_count + 3'd1;
                    end
                    return;
                end
                default: ;
            endcase
            if (!ok)
                r.value = '0;
            r.status = ok ? ST_OK : ST_BAD_FMT;
            predicted_pixels.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            results_checked++;
            if (predicted_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word value=%h status=%b last=%b",
                         $time, got.value, got.status, got.end_of_run);
                return;
            end
            exp_r = predicted_pixels.pop_front();
            if (got.value !== exp_r.value) begin
                errors++;
                $display("%0t: value mismatch expected %h actual %h",
                         $time, exp_r.value, got.value);
            end
            if (got.status !== exp_r.status) begin
                errors++;
                $display("%0t: status mismatch expected %b actual %b",
                         $time, exp_r.status, got.status);
            end
            if (got.end_of_run !== exp_r.end_of_run) begin
                errors++;
                $display("%0t: end_of_run mismatch expected %b actual %b",
                         $time, exp_r.end_of_run, got.end_of_run);
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                psel, penable, pwrite, pready;
    logic [ADDR_W-1:0]   paddr;
    logic [REG_W-1:0]    pwdata, prdata;
    logic                s_tvalid, s_tready, s_tlast;
    logic [S_DATA_W-1:0] s_tdata;   // command[2:0], pixel_a[18:3], pixel_b[34:19], zero pad
    logic                m_tvalid, m_tready, m_tlast;
    logic [M_DATA_W-1:0] m_tdata;   // value[15:0]
    logic                m_tuser;   // status

    pixel_scoreboard sb = new();
    bit          hold_req = 1'b0;
    bit          no_idle  = 1'b0;
    logic [31:0] cur_thr  = '0;
    int          cycles   = 0;

    saturating_pixel_arithmetic_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("FAIL");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [15:0] pick_pixel();
        logic [15:0] t;
        t = cur_thr[15:0];
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h00ff;
            3: return t + 16'($urandom_range(0, 2)) - 16'd1;
            4: return {8'h00, 8'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    // result side
    initial begin
        result_t got;
        int      stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got.value      = m_tdata;
                got.status     = m_tuser;
                got.end_of_run = m_tlast;
                sb.check_result(got);
            end
            @(negedge aclk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (no_idle) begin
                m_tready = 1'b1;
            end else begin
                stall_left = pick_gap();
                m_tready   = (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    task automatic send_pixel(logic [CMD_W-1:0] cmd, logic [15:0] a, logic [15:0] b,
                              logic fin);
        item_t it;
        int    gap;
        it.command     = cmd;
        it.pixel_a     = a;
        it.pixel_b     = b;
        it.final_pixel = fin;
        s_tvalid = 1'b1;
        s_tdata  = {5'b0, b, a, cmd};
        s_tlast  = fin;
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(it);
        @(negedge aclk);
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] v);
        logic [31:0] want;
        want    = (idx <= REG_RESULT_WIDE) ? {31'b0, v[0]} : v;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = v;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, v);
        @(negedge aclk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            sb.errors++;
            $display("%0t: register %0d read back expected %h actual %h",
                     $time, idx, want, prdata);
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (sb.predicted_pixels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic configure(logic [2:0] fmt, logic [31:0] scale, logic [31:0] thr);
        wait_idle();
        write_reg(REG_FIRST_WIDE,  {31'b0, fmt[2]});
        write_reg(REG_SECOND_WIDE, {31'b0, fmt[1]});
        write_reg(REG_RESULT_WIDE, {31'b0, fmt[0]});
        write_reg(REG_SCALE,       scale);
        write_reg(REG_THRESHOLD,   thr);
        cur_thr = thr;
    endtask

    // threshold runs mixed with runs of arithmetic and reserved commands
    task automatic run_random(int count);
        int left, len, r;
        logic [CMD_W-1:0] cmd;
        logic fin;
        left = count;
        while (left > 0) begin
            if ($urandom_range(0, 2) == 0) begin
                len = $urandom_range(1, 20);
                if (len > left)
                    len = left;
                for (int i = 0; i < len; i++) begin
                    fin = (i == len - 1) ? 1'($urandom_range(0, 1))
                                         : ($urandom_range(0, 29) == 0);
                    send_pixel(CMD_THRESHOLD, pick_pixel(), pick_pixel(), fin);
                end
            end else begin
                len = $urandom_range(1, 12);
                if (len > left)
                    len = left;
                for (int i = 0; i < len; i++) begin
                    r = $urandom_range(0, 19);
                    if (r < 16)
                        cmd = CMD_W'(r % 5);
                    else
                        cmd = CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
                    fin = ($urandom_range(0, 7) == 0);
                    send_pixel(cmd, pick_pixel(), pick_pixel(), fin);
                end
            end
            left -= len;
        end
    endtask

    initial begin
        logic [2:0]  fmts   [PHASES];
        logic [31:0] scales [PHASES];
        logic [31:0] thrs   [PHASES];
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: all narrow, scale 1, threshold 0
        send_pixel(CMD_ADD,     16'h00ff, 16'h0001, 1'b0);
        send_pixel(CMD_ADD,     16'h0000, 16'h0000, 1'b0);
        send_pixel(CMD_ADD,     16'hff12, 16'hab34, 1'b0);
        send_pixel(CMD_SUB,     16'h0010, 16'h0020, 1'b0);
        send_pixel(CMD_SUB,     16'h00ff, 16'h0001, 1'b0);
        send_pixel(CMD_SUB,     16'h0020, 16'h0020, 1'b0);
        send_pixel(CMD_ABSDIFF, 16'h0010, 16'h00f0, 1'b0);
        send_pixel(CMD_ABSDIFF, 16'hfff0, 16'h0010, 1'b0);
        send_pixel(CMD_SCALE,   16'h00ff, 16'hffff, 1'b0);
        send_pixel(CMD_ADD,     16'h0001, 16'h0002, 1'b1);
        for (int c = CMD_RSVD_LO; c <= CMD_RSVD_HI; c++)
            send_pixel(CMD_W'(c), 16'hffff, 16'hffff, 1'(c == CMD_RSVD_HI));
        for (int i = 0; i < 8; i++)
            send_pixel(CMD_THRESHOLD, 16'(i), 16'hffff, 1'b0);
        for (int i = 0; i < 3; i++)
            send_pixel(CMD_THRESHOLD, 16'h0000, 16'h0000, 1'(i == 2));

        fmts   = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
                   3'd0, 3'd7, 3'd4, 3'd1};
        scales = '{32'd0, 32'd2, 32'h000000ff, 32'h00000100, 32'h0000ffff,
                   32'h00010000, 32'hffffffff, 32'd1, 32'd3, 32'h00000123,
                   32'($urandom), 32'($urandom_range(0, 600))};
        thrs   = '{32'h00000080, 32'h000000ff, 32'h00000000, 32'h00000100,
                   32'h0000ffff, 32'hffffffff, 32'd1, 32'h00007fff,
                   32'($urandom_range(0, 255)), 32'($urandom_range(0, 65535)),
                   32'($urandom), 32'h00000040};
        for (int p = 0; p < PHASES; p++) begin
            configure(fmts[p], scales[p], thrs[p]);
            no_idle  = (p == 2 || p == 9);
            hold_req = (p == 4);
            run_random(PHASE_ITEMS);
        end
        no_idle = 1'b0;

        wait_idle();
        $display("covered %0d pixel words and %0d result words over %0d register settings",
                 sb.pixels_noted, sb.results_checked, PHASES + 1);
        $display("all commands, all eight formats, reserved codes and threshold packing");
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
